// ----- hdl/tcw_pkg.sv -----
package tcw_pkg;

    localparam int ROWS_DEFAULT = 25;
    localparam int COLS_DEFAULT = 80;

    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int TROW_W   = 5;
    localparam int TCOL_W   = 7;
    localparam int POS_W    = 11;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_ATTR = 1'd1;

    localparam logic [ATTR_W-1:0] TEXT_ATTR_RESET  = 8'd7;
    localparam logic [ATTR_W-1:0] BLANK_ATTR_RESET = 8'd15;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [ATTR_W-1:0] text_attr;
        logic [ATTR_W-1:0] blank_attr;
    } t_attr_cfg;

endpackage

// ----- hdl/tcw_if.sv -----
interface tcw_in_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [TROW_W-1:0] target_row;
    logic [TCOL_W-1:0] target_col;

    modport source (
        output valid, command, char_code, target_row, target_col,
        input  ready
    );
    modport sink (
        input  valid, command, char_code, target_row, target_col,
        output ready
    );
endinterface

interface tcw_out_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  cursor_position;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CELL_W-1:0] cell_value;

    modport source (
        output valid, cursor_position, cursor_row, cursor_col, cell_value,
        input  ready
    );
    modport sink (
        input  valid, cursor_position, cursor_row, cursor_col, cell_value,
        output ready
    );
endinterface

// ----- hdl/text_console_writer.sv -----
// Character-cell text console of ROWS x COLS 16-bit cells (character low byte,
// attribute high byte) held in a single-port-write, registered-read memory.
// One command is taken at a time and gives one word with the cursor after it.
// A put passes through PUT, a cursor move through CALC and a cell read through
// CALC, READ and READ_DATA before FINISH loads the word; a clear and a put that
// scrolls first pass every cell through the one memory write port, one cell a
// cycle. The block is back in idle as the word is loaded and takes the next
// command from there; a word not yet taken at the output holds the next one
// back until it is.
// After reset the block sweeps the memory to zero and accepts no command until
// that pass is done; configuration writes are taken at any time but are meant
// for when the block is idle.
module text_console_writer #(
    parameter int ROWS = tcw_pkg::ROWS_DEFAULT,
    parameter int COLS = tcw_pkg::COLS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tcw_in_if.sink                        i_in,
    tcw_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tcw_pkg::*;

    t_attr_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.text_attr  <= TEXT_ATTR_RESET;
            r_cfg.blank_attr <= BLANK_ATTR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TEXT_ATTR:  r_cfg.text_attr  <= i_cfg_data;
                REG_BLANK_ATTR: r_cfg.blank_attr <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    tcw_seq #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// ----- hdl/tcw_screen_ram.sv -----
module tcw_screen_ram #(
    parameter int DEPTH = tcw_pkg::ROWS_DEFAULT * tcw_pkg::COLS_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0] i_wr_data,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [tcw_pkg::CELL_W-1:0] o_rd_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/tcw_seq.sv -----
module tcw_seq #(
    parameter int ROWS = tcw_pkg::ROWS_DEFAULT,
    parameter int COLS = tcw_pkg::COLS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcw_pkg::t_attr_cfg i_cfg,
    tcw_in_if.sink             i_in,
    tcw_out_if.source          o_out
);
    import tcw_pkg::*;

    localparam int CELLS    = ROWS * COLS;
    localparam int AW       = $clog2(CELLS);
    localparam int RW       = $clog2(ROWS);
    localparam int CW       = $clog2(COLS);
    localparam int PW       = (AW > POS_W) ? AW : POS_W;
    localparam int RXW      = (RW > ROW_W) ? RW : ROW_W;
    localparam int CXW      = (CW > COL_W) ? CW : COL_W;
    localparam logic [AW-1:0] LAST_ROW  = AW'((ROWS - 1) * COLS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] COLS_A    = AW'(COLS);
    localparam logic [RW-1:0] ROW_MAX   = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_MAX   = CW'(COLS - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUT,
        ST_CALC,
        ST_READ,
        ST_READ_DATA,
        ST_FILL,
        ST_COPY,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        FILL_ZERO,
        FILL_CLEAR,
        FILL_BLANK
    } t_fill;

    t_state            r_state;
    t_fill             r_fill;
    t_cmd              r_cmd;
    logic [CHAR_W-1:0] r_char;
    logic [RW-1:0]     r_trow;
    logic [CW-1:0]     r_tcol;
    logic [AW-1:0]     r_tbase;
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic [AW-1:0]     r_base;
    logic [AW-1:0]     r_addr;
    logic              r_cp_vld;
    logic [AW-1:0]     r_cp_dst;
    logic [CELL_W-1:0] r_cell;

    logic              r_out_valid;
    logic [POS_W-1:0]  r_out_pos;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic [CELL_W-1:0] r_out_cell;

    logic              ram_we;
    logic [AW-1:0]     ram_wr_addr;
    logic [CELL_W-1:0] ram_wr_data;
    logic [AW-1:0]     ram_rd_addr;
    logic [CELL_W-1:0] ram_rd_data;

    logic [AW-1:0]     cur_addr;
    logic [CELL_W-1:0] fill_data;
    logic [PW-1:0]     pos_wide;
    logic [RXW-1:0]    row_wide;
    logic [CXW-1:0]    col_wide;
    logic [RW-1:0]     trow_clamp;
    logic [CW-1:0]     tcol_clamp;
    logic              line_end;

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign cur_addr = r_base + AW'(r_col);
    assign pos_wide = PW'(r_base) + PW'(r_col);
    assign row_wide = RXW'(r_row);
    assign col_wide = CXW'(r_col);
    assign line_end = (r_char == NEWLINE_CODE) || (r_col == COL_MAX);

    assign trow_clamp = (int'(i_in.target_row) >= ROWS) ? ROW_MAX : RW'(i_in.target_row);
    assign tcol_clamp = (int'(i_in.target_col) >= COLS) ? COL_MAX : CW'(i_in.target_col);

    always_comb begin
        case (r_fill)
            FILL_ZERO:  fill_data = '0;
            FILL_CLEAR: fill_data = {(r_addr >= LAST_ROW) ? i_cfg.blank_attr : i_cfg.text_attr,
                                     SPACE_CODE};
            FILL_BLANK: fill_data = {i_cfg.blank_attr, SPACE_CODE};
            default:    fill_data = '0;
        endcase
    end

    // one write port shared by fill, scroll copy and character put
    always_comb begin
        ram_we      = 1'b0;
        ram_wr_addr = r_addr;
        ram_wr_data = fill_data;
        ram_rd_addr = r_addr;
        case (r_state)
            ST_FILL: begin
                ram_we = 1'b1;
            end
            ST_COPY, ST_DRAIN: begin
                ram_we      = r_cp_vld;
                ram_wr_addr = r_cp_dst;
                ram_wr_data = ram_rd_data;
            end
            ST_PUT: begin
                ram_we      = (r_char != NEWLINE_CODE);
                ram_wr_addr = cur_addr;
                ram_wr_data = {i_cfg.text_attr, r_char};
            end
            ST_READ: begin
                ram_rd_addr = r_tbase + AW'(r_tcol);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign i_in.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_fill      <= FILL_ZERO;
            r_addr      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_cp_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cp_vld <= (r_state == ST_COPY);
            if (r_out_valid && o_out.ready && r_state != ST_FINISH) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_cmd  <= t_cmd'(i_in.command);
                        r_char <= i_in.char_code;
                        r_trow <= trow_clamp;
                        r_tcol <= tcol_clamp;
                        r_cell <= '0;
                        case (t_cmd'(i_in.command))
                            CMD_PUT: begin
                                r_state <= ST_PUT;
                            end
                            CMD_CLEAR: begin
                                r_fill  <= FILL_CLEAR;
                                r_addr  <= '0;
                                r_row   <= '0;
                                r_col   <= '0;
                                r_base  <= '0;
                                r_state <= ST_FILL;
                            end
                            default: begin
                                r_state <= ST_CALC;
                            end
                        endcase
                    end
                end
                ST_PUT: begin
                    if (line_end) begin
                        r_col <= '0;
                        if (r_row == ROW_MAX) begin
                            // scroll: stream rows 1..last up by one line
                            r_addr  <= COLS_A;
                            r_state <= ST_COPY;
                        end else begin
                            r_row   <= r_row + 1'b1;
                            r_base  <= r_base + COLS_A;
                            r_state <= ST_FINISH;
                        end
                    end else begin
                        r_col   <= r_col + 1'b1;
                        r_state <= ST_FINISH;
                    end
                end
                ST_CALC: begin
                    r_tbase <= AW'(r_trow * COLS);
                    if (r_cmd == CMD_MOVE) begin
                        r_row   <= r_trow;
                        r_col   <= r_tcol;
                        r_base  <= AW'(r_trow * COLS);
                        r_state <= ST_FINISH;
                    end else begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_READ_DATA;
                end
                ST_READ_DATA: begin
                    r_cell  <= ram_rd_data;
                    r_state <= ST_FINISH;
                end
                ST_COPY: begin
                    r_cp_dst <= r_addr - COLS_A;
                    if (r_addr == LAST_CELL) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    r_fill  <= FILL_BLANK;
                    r_addr  <= LAST_ROW;
                    r_state <= ST_FILL;
                end
                ST_FILL: begin
                    if (r_addr == LAST_CELL) begin
                        r_state <= (r_fill == FILL_ZERO) ? ST_IDLE : ST_FINISH;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                ST_FINISH: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_pos   <= pos_wide[POS_W-1:0];
                        r_out_row   <= row_wide[ROW_W-1:0];
                        r_out_col   <= col_wide[COL_W-1:0];
                        r_out_cell  <= r_cell;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.cursor_position = r_out_pos;
    assign o_out.cursor_row      = r_out_row;
    assign o_out.cursor_col      = r_out_col;
    assign o_out.cell_value      = r_out_cell;

endmodule

// ----- sim/text_console_writer_tb.sv -----
module text_console_writer_tb;
    import tcw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS  = ROWS_DEFAULT;
    localparam int COLS  = COLS_DEFAULT;
    localparam int CELLS = ROWS * COLS;

    typedef struct {
        t_cmd              cmd;
        logic [CHAR_W-1:0] ch;
        logic [TROW_W-1:0] trow;
        logic [TCOL_W-1:0] tcol;
    } t_console_cmd;

    typedef struct {
        logic [POS_W-1:0]  pos;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CELL_W-1:0] cell_val;
    } t_cursor_word;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tcw_in_if  cmd_if ();
    tcw_out_if word_if ();

    text_console_writer #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (cmd_if),
        .o_out       (word_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    t_console_cmd pending_cmds [$];
    t_cursor_word expected_words [$];

    // shadow copy of the console state
    logic [CELL_W-1:0] shadow_cells [0:CELLS-1];
    int unsigned       shadow_row;
    int unsigned       shadow_col;
    logic [ATTR_W-1:0] shadow_text_attr;
    logic [ATTR_W-1:0] shadow_blank_attr;

    int  errors;
    int  words_seen;
    int  send_gap;
    int  recv_gap;
    int  hold_off;
    bit  idle_on;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #250ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void console_newline();
        shadow_col = 0;
        shadow_row++;
        if (shadow_row >= ROWS) begin
            for (int i = 0; i < (ROWS - 1) * COLS; i++)
                shadow_cells[i] = shadow_cells[i + COLS];
            for (int i = 0; i < COLS; i++)
                shadow_cells[(ROWS - 1) * COLS + i] = {shadow_blank_attr, SPACE_CODE};
            shadow_row = ROWS - 1;
        end
    endfunction

    function automatic t_cursor_word advance_console(t_console_cmd c);
        t_cursor_word w;
        int unsigned  r;
        int unsigned  col;
        logic [CELL_W-1:0] rd_val;
        r      = (c.trow >= ROWS) ? ROWS - 1 : c.trow;
        col    = (c.tcol >= COLS) ? COLS - 1 : c.tcol;
        rd_val = '0;
        case (c.cmd)
            CMD_PUT: begin
                if (c.ch == NEWLINE_CODE) begin
                    console_newline();
                end else begin
                    shadow_cells[shadow_row * COLS + shadow_col] = {shadow_text_attr, c.ch};
                    shadow_col++;
                    if (shadow_col >= COLS)
                        console_newline();
                end
            end
            CMD_MOVE: begin
                shadow_row = r;
                shadow_col = col;
            end
            CMD_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    shadow_cells[i] = {(i < (ROWS - 1) * COLS) ? shadow_text_attr
                                                              : shadow_blank_attr,
                                       SPACE_CODE};
                shadow_row = 0;
                shadow_col = 0;
            end
            default: begin
                rd_val = shadow_cells[r * COLS + col];
            end
        endcase
        w.pos      = POS_W'(shadow_row * COLS + shadow_col);
        w.row      = ROW_W'(shadow_row);
        w.col      = COL_W'(shadow_col);
        w.cell_val = rd_val;
        return w;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void report_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // command driver
    always @(posedge i_clk) begin
        logic took;
        took = cmd_if.valid && cmd_if.ready;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (took) begin
                expected_words.push_back(advance_console(pending_cmds[0]));
                void'(pending_cmds.pop_front());
                send_gap = pick_gap();
            end
            if (cmd_if.valid && !took) begin
                // keep offering the same command
            end else if (send_gap > 0 || pending_cmds.size() == 0) begin
                if (send_gap > 0)
                    send_gap--;
                cmd_if.valid <= 1'b0;
            end else begin
                cmd_if.valid      <= 1'b1;
                cmd_if.command    <= pending_cmds[0].cmd;
                cmd_if.char_code  <= pending_cmds[0].ch;
                cmd_if.target_row <= pending_cmds[0].trow;
                cmd_if.target_col <= pending_cmds[0].tcol;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_cursor_word want;
        if (!i_rst_n) begin
            word_if.ready <= 1'b0;
        end else begin
            if (word_if.valid && word_if.ready) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual pos %0d cell %h",
                             $time, word_if.cursor_position, word_if.cell_value);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    report_field("cursor_position", want.pos, word_if.cursor_position);
                    report_field("cursor_row", want.row, word_if.cursor_row);
                    report_field("cursor_col", want.col, word_if.cursor_col);
                    report_field("cell_value", want.cell_val, word_if.cell_value);
                end
                // one long back-pressure stretch so the input side stalls
                if (words_seen == 150)
                    hold_off = 500;
            end
            if (hold_off > 0) begin
                hold_off--;
                word_if.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                word_if.ready <= 1'b0;
            end else begin
                word_if.ready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    task automatic push_cmd(input t_cmd c, input logic [CHAR_W-1:0] ch,
                            input logic [TROW_W-1:0] r, input logic [TCOL_W-1:0] col);
        t_console_cmd item;
        item.cmd  = c;
        item.ch   = ch;
        item.trow = r;
        item.tcol = col;
        pending_cmds.push_back(item);
    endtask

    function automatic logic [TROW_W-1:0] rand_row();
        if ($urandom_range(0, 7) == 0)
            return TROW_W'($urandom_range(0, 31));
        return TROW_W'($urandom_range(0, ROWS - 1));
    endfunction

    function automatic logic [TCOL_W-1:0] rand_col();
        if ($urandom_range(0, 7) == 0)
            return TCOL_W'($urandom_range(0, 127));
        return TCOL_W'($urandom_range(0, COLS - 1));
    endfunction

    function automatic logic [CHAR_W-1:0] rand_text_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return NEWLINE_CODE;
        else if (r < 80)
            return CHAR_W'($urandom_range(32, 126));
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic queue_random_phase(input int n);
        int made;
        int r;
        int len;
        made = 0;
        while (made < n) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                // a line of text, often near the bottom so it scrolls
                if ($urandom_range(0, 9) < 3) begin
                    push_cmd(CMD_MOVE, CHAR_W'($urandom),
                             TROW_W'(ROWS - 1 - $urandom_range(0, 1)), rand_col());
                    made++;
                end
                len = $urandom_range(1, 12);
                repeat (len)
                    push_cmd(CMD_PUT, rand_text_char(), TROW_W'($urandom), TCOL_W'($urandom));
                made += len;
            end else if (r < 68) begin
                push_cmd(CMD_MOVE, CHAR_W'($urandom), rand_row(), rand_col());
                made++;
            end else if (r < 88) begin
                push_cmd(CMD_READ, CHAR_W'($urandom), rand_row(), rand_col());
                made++;
            end else if (r < 92) begin
                push_cmd(CMD_CLEAR, CHAR_W'($urandom), TROW_W'($urandom), TCOL_W'($urandom));
                made++;
            end else begin
                push_cmd(t_cmd'($urandom_range(0, 3)), CHAR_W'($urandom), TROW_W'($urandom),
                         TCOL_W'($urandom));
                made++;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ATTR_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == REG_TEXT_ATTR)
            shadow_text_attr = val;
        else
            shadow_blank_attr = val;
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_words.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        logic [ATTR_W-1:0] text_vals  [6];
        logic [ATTR_W-1:0] blank_vals [6];

        errors     = 0;
        words_seen = 0;
        send_gap   = 0;
        recv_gap   = 0;
        hold_off   = 0;
        idle_on    = 1'b1;

        cmd_if.valid      = 1'b0;
        cmd_if.command    = CMD_PUT;
        cmd_if.char_code  = '0;
        cmd_if.target_row = '0;
        cmd_if.target_col = '0;
        word_if.ready     = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_TEXT_ATTR;
        cfg_data          = '0;
        i_rst_n           = 1'b0;

        for (int i = 0; i < CELLS; i++)
            shadow_cells[i] = '0;
        shadow_row        = 0;
        shadow_col        = 0;
        shadow_text_attr  = TEXT_ATTR_RESET;
        shadow_blank_attr = BLANK_ATTR_RESET;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, reset attributes
        @(negedge i_clk);
        push_cmd(CMD_READ, 8'd0, 5'd0, 7'd0);
        push_cmd(CMD_READ, 8'd0, 5'd31, 7'd127);
        push_cmd(CMD_PUT, 8'd65, 5'd0, 7'd0);
        push_cmd(CMD_PUT, 8'd0, 5'd31, 7'd127);
        push_cmd(CMD_PUT, 8'd255, 5'd0, 7'd0);
        push_cmd(CMD_READ, 8'd0, 5'd0, 7'd2);
        push_cmd(CMD_MOVE, 8'd0, 5'd0, 7'(COLS - 2));
        push_cmd(CMD_PUT, 8'd120, 5'd0, 7'd0);
        push_cmd(CMD_PUT, 8'd121, 5'd0, 7'd0);
        push_cmd(CMD_PUT, NEWLINE_CODE, 5'd0, 7'd0);
        push_cmd(CMD_MOVE, 8'd0, 5'(ROWS - 1), 7'd5);
        push_cmd(CMD_PUT, NEWLINE_CODE, 5'd0, 7'd0);
        push_cmd(CMD_READ, 8'd0, 5'(ROWS - 1), 7'd0);
        push_cmd(CMD_READ, 8'd0, 5'(ROWS - 2), 7'd0);
        push_cmd(CMD_MOVE, 8'd0, 5'd31, 7'd127);
        push_cmd(CMD_PUT, 8'd122, 5'd0, 7'd0);
        push_cmd(CMD_READ, 8'd0, 5'(ROWS - 2), 7'(COLS - 1));
        push_cmd(CMD_READ, 8'd0, 5'd0, 7'd0);
        push_cmd(CMD_CLEAR, 8'd0, 5'd0, 7'd0);
        push_cmd(CMD_READ, 8'd0, 5'd0, 7'd0);
        push_cmd(CMD_READ, 8'd0, 5'(ROWS - 1), 7'(COLS - 1));
        push_cmd(CMD_READ, 8'd0, 5'(ROWS - 2), 7'(COLS - 1));
        push_cmd(CMD_MOVE, 8'd0, 5'(ROWS - 1), 7'(COLS - 1));
        push_cmd(CMD_MOVE, 8'd0, 5'd0, 7'd0);
        wait_drained();

        text_vals[0]  = 8'hFF; blank_vals[0] = 8'h00;
        text_vals[1]  = 8'h00; blank_vals[1] = 8'hFF;
        text_vals[2]  = ATTR_W'($urandom); blank_vals[2] = ATTR_W'($urandom);
        text_vals[3]  = 8'h00; blank_vals[3] = 8'h00;
        text_vals[4]  = 8'hFF; blank_vals[4] = 8'hFF;
        text_vals[5]  = ATTR_W'($urandom); blank_vals[5] = ATTR_W'($urandom);

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_TEXT_ATTR, text_vals[ph]);
            write_reg(REG_BLANK_ATTR, blank_vals[ph]);
            @(negedge i_clk);
            // one phase runs without any idling
            idle_on = (ph != 2);
            queue_random_phase(305);
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
